[rtl/hccf_pkg.sv]
package hccf_pkg;

  localparam int FUNC_W  = 2;
  localparam int PID_W   = 12;
  localparam int MOD_W   = 4;
  localparam int CHIP_W  = 5;
  localparam int CHAN_W  = 8;
  localparam int ADC_W   = 4;
  localparam int AMPL_W  = 7;
  localparam int XING_W  = 8;
  localparam int COUNT_W = 9;

  // Noise key is {packet, module, chip, channel}; hit key appends the ADC code.
  localparam int NKEY_W = PID_W + MOD_W + CHIP_W + CHAN_W;
  localparam int HKEY_W = NKEY_W + ADC_W;

  // Match bits are OR-ed in registered groups of this size.
  localparam int GROUP_SIZE = 16;

  localparam logic [FUNC_W-1:0] FUNC_HIT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [PID_W-1:0]   PID_MIN   = 12'd3001;
  localparam logic [PID_W-1:0]   PID_MAX   = 12'd3008;
  localparam logic [ADC_W-1:0]   ADC_MAX   = 4'd8;
  localparam logic [AMPL_W-1:0]  AMPL_MAX  = 7'd63;
  localparam logic [CHIP_W-1:0]  CHIP_MIN  = 5'd1;
  localparam logic [CHIP_W-1:0]  CHIP_MAX  = 5'd26;
  localparam logic [MOD_W-1:0]   MOD_MAX   = 4'd13;
  localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'd128;
  localparam logic [XING_W-1:0]  XING_MAX  = 8'd127;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PID_W-1:0]  packet_id;
    logic [MOD_W-1:0]  module_num;
    logic [CHIP_W-1:0] chip_num;
    logic [CHAN_W-1:0] channel_num;
    logic [ADC_W-1:0]  adc_value;
    logic [AMPL_W-1:0] amplitude;
    logic [XING_W-1:0] crossing;
  } item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_FIN
  } state_t;

  function automatic count_t sat_inc(count_t v);
    return (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

endpackage

[rtl/hccf_in_if.sv]
interface hccf_in_if;
  logic                         valid;
  logic                         ready;
  logic [hccf_pkg::FUNC_W-1:0]  func;
  logic [hccf_pkg::PID_W-1:0]   packet_id;
  logic [hccf_pkg::MOD_W-1:0]   module_num;
  logic [hccf_pkg::CHIP_W-1:0]  chip_num;
  logic [hccf_pkg::CHAN_W-1:0]  channel_num;
  logic [hccf_pkg::ADC_W-1:0]   adc_value;
  logic [hccf_pkg::AMPL_W-1:0]  amplitude;
  logic [hccf_pkg::XING_W-1:0]  crossing;

  modport source (
    output valid, func, packet_id, module_num, chip_num, channel_num,
           adc_value, amplitude, crossing,
    input  ready
  );

  modport sink (
    input  valid, func, packet_id, module_num, chip_num, channel_num,
           adc_value, amplitude, crossing,
    output ready
  );
endinterface

[rtl/hccf_out_if.sv]
interface hccf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          clone_flag;
  logic                          noise_flag;
  logic                          fields_ok;
  logic [hccf_pkg::COUNT_W-1:0]  kept_no_clone;
  logic [hccf_pkg::COUNT_W-1:0]  kept_no_noise;
  logic [hccf_pkg::COUNT_W-1:0]  kept_clean;
  logic                          table_full;

  modport source (
    output valid, clone_flag, noise_flag, fields_ok, kept_no_clone,
           kept_no_noise, kept_clean, table_full,
    input  ready
  );

  modport sink (
    input  valid, clone_flag, noise_flag, fields_ok, kept_no_clone,
           kept_no_noise, kept_clean, table_full,
    output ready
  );
endinterface

[rtl/hccf_cell.sv]
module hccf_cell #(
  parameter int KEY_W = 29
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic             en,
  input  logic [KEY_W-1:0] key,
  input  logic [KEY_W-1:0] din,
  output logic [KEY_W-1:0] entry,
  output logic             match_r
);

  logic [KEY_W-1:0] entry_r;

  // On a store every cell takes its neighbor's entry; the new key enters cell 0.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= din;
    end
    match_r <= en && (entry_r == key);
  end

  assign entry = entry_r;

endmodule

[rtl/hccf_cam_row.sv]
module hccf_cam_row #(
  parameter int DEPTH = 64,
  parameter int KEY_W = 29,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] count,
  output logic             hit
);

  localparam int GS   = hccf_pkg::GROUP_SIZE;
  localparam int NGRP = (DEPTH + GS - 1) / GS;

  logic [KEY_W-1:0]   chain [DEPTH+1];
  logic [DEPTH-1:0]   match;
  logic [NGRP*GS-1:0] match_pad;
  logic [NGRP-1:0]    grp_r;

  assign chain[0] = key;

  // The newest entries sit at the low end, so cell i holds live data while i < count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    hccf_cell #(.KEY_W(KEY_W)) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .en       (count > CNT_W'(i)),
      .key      (key),
      .din      (chain[i]),
      .entry    (chain[i+1]),
      .match_r  (match[i])
    );
  end

  assign match_pad = (NGRP*GS)'(match);

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_ff @(posedge clk) begin
      grp_r[g] <= |match_pad[g*GS +: GS];
    end
  end

  assign hit = |grp_r;

endmodule

[rtl/hit_clone_and_hot_channel_filter.sv]
// Hot-channel mask and duplicate-hit filter.
// Input channel in_ch carries one item per transfer: a hit, a noisy-channel
// entry to load, or an event clear, selected by func. Every accepted item
// gives exactly one result on out_ch: clone and noise flags, a range check,
// the running kept-hit counts of the event and a table-full flag.
// Noise entries and event hits live in two rows of cells that shift on each
// store and compare all entries against the item at once; match bits are
// reduced through one registered level of 16-wide groups.
// An item passes through the accept, compare, group reduce, and final OR and
// update stages in order; the result is registered, and in_ch.ready is high
// only in the accept stage, so the block takes no new item until the current
// one has left the final stage.
// After reset both tables and all counts are empty; no clearing pass runs.
// The result sits in an output register: the next item is accepted while it
// waits, and a stalled receiver holds the following item in its final stage.
module hit_clone_and_hot_channel_filter #(
  parameter int NOISY_ENTRIES = 64,
  parameter int EVENT_HITS    = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  hccf_in_if.sink         in_ch,
  hccf_out_if.source      out_ch
);

  localparam int NC_W = $clog2(NOISY_ENTRIES + 1);
  localparam int EC_W = $clog2(EVENT_HITS + 1);

  hccf_pkg::state_t state_r, state_nxt;
  hccf_pkg::item_t  item_r;

  logic [NC_W-1:0] noisy_count_r, noisy_count_nxt;
  logic [EC_W-1:0] event_count_r, event_count_nxt;
  hccf_pkg::count_t no_clone_r, no_clone_nxt;
  hccf_pkg::count_t no_noise_r, no_noise_nxt;
  hccf_pkg::count_t clean_r, clean_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             clone_r, noise_r, ok_r, full_r;
  logic             clone_nxt, noise_nxt, ok_nxt, full_nxt;

  logic [hccf_pkg::NKEY_W-1:0] nkey;
  logic [hccf_pkg::HKEY_W-1:0] hkey;
  logic noisy_hit, event_hit;
  logic noisy_shift, event_shift;
  logic commit;

  assign nkey = {item_r.packet_id, item_r.module_num, item_r.chip_num, item_r.channel_num};
  assign hkey = {nkey, item_r.adc_value};

  hccf_cam_row #(.DEPTH(NOISY_ENTRIES), .KEY_W(hccf_pkg::NKEY_W)) u_noisy_row (
    .clk      (clk),
    .shift_en (noisy_shift),
    .key      (nkey),
    .count    (noisy_count_r),
    .hit      (noisy_hit)
  );

  hccf_cam_row #(.DEPTH(EVENT_HITS), .KEY_W(hccf_pkg::HKEY_W)) u_event_row (
    .clk      (clk),
    .shift_en (event_shift),
    .key      (hkey),
    .count    (event_count_r),
    .hit      (event_hit)
  );

  assign in_ch.ready = (state_r == hccf_pkg::S_IDLE);
  assign commit      = (state_r == hccf_pkg::S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt       = state_r;
    noisy_count_nxt = noisy_count_r;
    event_count_nxt = event_count_r;
    no_clone_nxt    = no_clone_r;
    no_noise_nxt    = no_noise_r;
    clean_nxt       = clean_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    clone_nxt       = 1'b0;
    noise_nxt       = 1'b0;
    ok_nxt          = 1'b0;
    full_nxt        = 1'b0;
    noisy_shift     = 1'b0;
    event_shift     = 1'b0;

    case (state_r)
      hccf_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = hccf_pkg::S_CMP;
        end
      end
      hccf_pkg::S_CMP: begin
        state_nxt = hccf_pkg::S_RED;
      end
      hccf_pkg::S_RED: begin
        state_nxt = hccf_pkg::S_FIN;
      end
      hccf_pkg::S_FIN: begin
        if (commit) begin
          state_nxt     = hccf_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
          case (item_r.func)
            hccf_pkg::FUNC_HIT: begin
              clone_nxt = event_hit;
              noise_nxt = noisy_hit;
              ok_nxt    = (item_r.packet_id >= hccf_pkg::PID_MIN) &&
                          (item_r.packet_id <= hccf_pkg::PID_MAX) &&
                          (item_r.adc_value <= hccf_pkg::ADC_MAX) &&
                          (item_r.amplitude <= hccf_pkg::AMPL_MAX) &&
                          (item_r.chip_num >= hccf_pkg::CHIP_MIN) &&
                          (item_r.chip_num <= hccf_pkg::CHIP_MAX) &&
                          (item_r.module_num <= hccf_pkg::MOD_MAX) &&
                          (item_r.channel_num <= hccf_pkg::CHAN_MAX) &&
                          (item_r.crossing <= hccf_pkg::XING_MAX);
              if (event_count_r != EC_W'(EVENT_HITS)) begin
                event_shift     = 1'b1;
                event_count_nxt = event_count_r + EC_W'(1);
                if (!event_hit) begin
                  no_clone_nxt = hccf_pkg::sat_inc(no_clone_r);
                end
                if (!noisy_hit) begin
                  no_noise_nxt = hccf_pkg::sat_inc(no_noise_r);
                end
                if (!event_hit && !noisy_hit) begin
                  clean_nxt = hccf_pkg::sat_inc(clean_r);
                end
              end else begin
                full_nxt = 1'b1;
              end
            end
            hccf_pkg::FUNC_LOAD: begin
              if (noisy_count_r != NC_W'(NOISY_ENTRIES)) begin
                noisy_shift     = 1'b1;
                noisy_count_nxt = noisy_count_r + NC_W'(1);
              end else begin
                full_nxt = 1'b1;
              end
            end
            hccf_pkg::FUNC_CLEAR: begin
              event_count_nxt = '0;
              no_clone_nxt    = '0;
              no_noise_nxt    = '0;
              clean_nxt       = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = hccf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= hccf_pkg::S_IDLE;
      noisy_count_r <= '0;
      event_count_r <= '0;
      no_clone_r    <= '0;
      no_noise_r    <= '0;
      clean_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      noisy_count_r <= noisy_count_nxt;
      event_count_r <= event_count_nxt;
      no_clone_r    <= no_clone_nxt;
      no_noise_r    <= no_noise_nxt;
      clean_r       <= clean_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.func        <= in_ch.func;
      item_r.packet_id   <= in_ch.packet_id;
      item_r.module_num  <= in_ch.module_num;
      item_r.chip_num    <= in_ch.chip_num;
      item_r.channel_num <= in_ch.channel_num;
      item_r.adc_value   <= in_ch.adc_value;
      item_r.amplitude   <= in_ch.amplitude;
      item_r.crossing    <= in_ch.crossing;
    end
    if (commit) begin
      clone_r <= clone_nxt;
      noise_r <= noise_nxt;
      ok_r    <= ok_nxt;
      full_r  <= full_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.clone_flag    = clone_r;
  assign out_ch.noise_flag    = noise_r;
  assign out_ch.fields_ok     = ok_r;
  assign out_ch.kept_no_clone = no_clone_r;
  assign out_ch.kept_no_noise = no_noise_r;
  assign out_ch.kept_clean    = clean_r;
  assign out_ch.table_full    = full_r;

`ifndef ASSERT_OFF
  a_event_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    event_count_r <= EC_W'(EVENT_HITS))
    else $error("event hit count exceeds the table depth");

  a_noisy_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    noisy_count_r <= NC_W'(NOISY_ENTRIES))
    else $error("noisy entry count exceeds the table depth");

  a_clean_le_others: assert property (@(posedge clk) disable iff (!rst_n)
    (clean_r <= no_clone_r) && (clean_r <= no_noise_r))
    else $error("clean count exceeds a partial count");

  a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == hccf_pkg::S_FIN))
    else $error("result raised outside the final stage");

  a_accept_starts_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == hccf_pkg::S_CMP))
    else $error("accepted item did not enter the compare stage");
`endif

endmodule
